[design/des_pkg.sv]
// DES round package: field types, E/P/S tables and table helper functions.
package des_pkg;

    localparam int HALF_W    = 32;
    localparam int KEY_W     = 48;
    localparam int S_TDATA_W = 2 * HALF_W + KEY_W;  // 112 bits, 14 bytes
    localparam int M_TDATA_W = 2 * HALF_W;          // 64 bits, 8 bytes

    typedef logic [HALF_W-1:0] half_t;
    typedef logic [KEY_W-1:0]  key_t;

    // Tables use DES bit numbering: bit 1 is the MSB.
    localparam logic [5:0] EXP_TAB [48] = '{
        6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
        6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
        6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
        6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
    };

    localparam logic [5:0] PERM_TAB [32] = '{
        6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
        6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
        6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
        6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
    };

    localparam logic [3:0] SBOX_TAB [8][64] = '{
        '{ 4'd14, 4'd4,  4'd13, 4'd1,  4'd2,  4'd15, 4'd11, 4'd8,
           4'd3,  4'd10, 4'd6,  4'd12, 4'd5,  4'd9,  4'd0,  4'd7,
           4'd0,  4'd15, 4'd7,  4'd4,  4'd14, 4'd2,  4'd13, 4'd1,
           4'd10, 4'd6,  4'd12, 4'd11, 4'd9,  4'd5,  4'd3,  4'd8,
           4'd4,  4'd1,  4'd14, 4'd8,  4'd13, 4'd6,  4'd2,  4'd11,
           4'd15, 4'd12, 4'd9,  4'd7,  4'd3,  4'd10, 4'd5,  4'd0,
           4'd15, 4'd12, 4'd8,  4'd2,  4'd4,  4'd9,  4'd1,  4'd7,
           4'd5,  4'd11, 4'd3,  4'd14, 4'd10, 4'd0,  4'd6,  4'd13 },
        '{ 4'd15, 4'd1,  4'd8,  4'd14, 4'd6,  4'd11, 4'd3,  4'd4,
           4'd9,  4'd7,  4'd2,  4'd13, 4'd12, 4'd0,  4'd5,  4'd10,
           4'd3,  4'd13, 4'd4,  4'd7,  4'd15, 4'd2,  4'd8,  4'd14,
           4'd12, 4'd0,  4'd1,  4'd10, 4'd6,  4'd9,  4'd11, 4'd5,
           4'd0,  4'd14, 4'd7,  4'd11, 4'd10, 4'd4,  4'd13, 4'd1,
           4'd5,  4'd8,  4'd12, 4'd6,  4'd9,  4'd3,  4'd2,  4'd15,
           4'd13, 4'd8,  4'd10, 4'd1,  4'd3,  4'd15, 4'd4,  4'd2,
           4'd11, 4'd6,  4'd7,  4'd12, 4'd0,  4'd5,  4'd14, 4'd9 },
        '{ 4'd10, 4'd0,  4'd9,  4'd14, 4'd6,  4'd3,  4'd15, 4'd5,
           4'd1,  4'd13, 4'd12, 4'd7,  4'd11, 4'd4,  4'd2,  4'd8,
           4'd13, 4'd7,  4'd0,  4'd9,  4'd3,  4'd4,  4'd6,  4'd10,
           4'd2,  4'd8,  4'd5,  4'd14, 4'd12, 4'd11, 4'd15, 4'd1,
           4'd13, 4'd6,  4'd4,  4'd9,  4'd8,  4'd15, 4'd3,  4'd0,
           4'd11, 4'd1,  4'd2,  4'd12, 4'd5,  4'd10, 4'd14, 4'd7,
           4'd1,  4'd10, 4'd13, 4'd0,  4'd6,  4'd9,  4'd8,  4'd7,
           4'd4,  4'd15, 4'd14, 4'd3,  4'd11, 4'd5,  4'd2,  4'd12 },
        '{ 4'd7,  4'd13, 4'd14, 4'd3,  4'd0,  4'd6,  4'd9,  4'd10,
           4'd1,  4'd2,  4'd8,  4'd5,  4'd11, 4'd12, 4'd4,  4'd15,
           4'd13, 4'd8,  4'd11, 4'd5,  4'd6,  4'd15, 4'd0,  4'd3,
           4'd4,  4'd7,  4'd2,  4'd12, 4'd1,  4'd10, 4'd14, 4'd9,
           4'd10, 4'd6,  4'd9,  4'd0,  4'd12, 4'd11, 4'd7,  4'd13,
           4'd15, 4'd1,  4'd3,  4'd14, 4'd5,  4'd2,  4'd8,  4'd4,
           4'd3,  4'd15, 4'd0,  4'd6,  4'd10, 4'd1,  4'd13, 4'd8,
           4'd9,  4'd4,  4'd5,  4'd11, 4'd12, 4'd7,  4'd2,  4'd14 },
        '{ 4'd2,  4'd12, 4'd4,  4'd1,  4'd7,  4'd10, 4'd11, 4'd6,
           4'd8,  4'd5,  4'd3,  4'd15, 4'd13, 4'd0,  4'd14, 4'd9,
           4'd14, 4'd11, 4'd2,  4'd12, 4'd4,  4'd7,  4'd13, 4'd1,
           4'd5,  4'd0,  4'd15, 4'd10, 4'd3,  4'd9,  4'd8,  4'd6,
           4'd4,  4'd2,  4'd1,  4'd11, 4'd10, 4'd13, 4'd7,  4'd8,
           4'd15, 4'd9,  4'd12, 4'd5,  4'd6,  4'd3,  4'd0,  4'd14,
           4'd11, 4'd8,  4'd12, 4'd7,  4'd1,  4'd14, 4'd2,  4'd13,
           4'd6,  4'd15, 4'd0,  4'd9,  4'd10, 4'd4,  4'd5,  4'd3 },
        '{ 4'd12, 4'd1,  4'd10, 4'd15, 4'd9,  4'd2,  4'd6,  4'd8,
           4'd0,  4'd13, 4'd3,  4'd4,  4'd14, 4'd7,  4'd5,  4'd11,
           4'd10, 4'd15, 4'd4,  4'd2,  4'd7,  4'd12, 4'd9,  4'd5,
           4'd6,  4'd1,  4'd13, 4'd14, 4'd0,  4'd11, 4'd3,  4'd8,
           4'd9,  4'd14, 4'd15, 4'd5,  4'd2,  4'd8,  4'd12, 4'd3,
           4'd7,  4'd0,  4'd4,  4'd10, 4'd1,  4'd13, 4'd11, 4'd6,
           4'd4,  4'd3,  4'd2,  4'd12, 4'd9,  4'd5,  4'd15, 4'd10,
           4'd11, 4'd14, 4'd1,  4'd7,  4'd6,  4'd0,  4'd8,  4'd13 },
        '{ 4'd4,  4'd11, 4'd2,  4'd14, 4'd15, 4'd0,  4'd8,  4'd13,
           4'd3,  4'd12, 4'd9,  4'd7,  4'd5,  4'd10, 4'd6,  4'd1,
           4'd13, 4'd0,  4'd11, 4'd7,  4'd4,  4'd9,  4'd1,  4'd10,
           4'd14, 4'd3,  4'd5,  4'd12, 4'd2,  4'd15, 4'd8,  4'd6,
           4'd1,  4'd4,  4'd11, 4'd13, 4'd12, 4'd3,  4'd7,  4'd14,
           4'd10, 4'd15, 4'd6,  4'd8,  4'd0,  4'd5,  4'd9,  4'd2,
           4'd6,  4'd11, 4'd13, 4'd8,  4'd1,  4'd4,  4'd10, 4'd7,
           4'd9,  4'd5,  4'd0,  4'd15, 4'd14, 4'd2,  4'd3,  4'd12 },
        '{ 4'd13, 4'd2,  4'd8,  4'd4,  4'd6,  4'd15, 4'd11, 4'd1,
           4'd10, 4'd9,  4'd3,  4'd14, 4'd5,  4'd0,  4'd12, 4'd7,
           4'd1,  4'd15, 4'd13, 4'd8,  4'd10, 4'd3,  4'd7,  4'd4,
           4'd12, 4'd5,  4'd6,  4'd11, 4'd0,  4'd14, 4'd9,  4'd2,
           4'd7,  4'd11, 4'd4,  4'd1,  4'd9,  4'd12, 4'd14, 4'd2,
           4'd0,  4'd6,  4'd10, 4'd13, 4'd15, 4'd3,  4'd5,  4'd8,
           4'd2,  4'd1,  4'd14, 4'd7,  4'd4,  4'd10, 4'd8,  4'd13,
           4'd15, 4'd12, 4'd9,  4'd0,  4'd3,  4'd5,  4'd6,  4'd11 }
    };

    // E expansion: 32 -> 48 bits, pure wiring.
    function automatic key_t expand(input half_t r);
        key_t ex;
        for (int n = 0; n < KEY_W; n++) begin
            ex[KEY_W-1-n] = r[5'(HALF_W - int'(EXP_TAB[n]))];
        end
        return ex;
    endfunction

    // S-box lookup: outer bits pick the row, middle four the column.
    function automatic logic [3:0] sbox(input logic [2:0] box, input logic [5:0] six);
        logic [5:0] addr;
        addr = {six[5], six[0], six[4:1]};
        return SBOX_TAB[box][addr];
    endfunction

    // P permutation, pure wiring.
    function automatic half_t permute(input half_t s);
        half_t p;
        for (int n = 0; n < HALF_W; n++) begin
            p[HALF_W-1-n] = s[5'(HALF_W - int'(PERM_TAB[n]))];
        end
        return p;
    endfunction

endpackage

[design/des_feistel_f.sv]
// DES f function: E expansion, key mix, eight S-boxes, P permutation.
module des_feistel_f (
    input  des_pkg::half_t right_half,
    input  des_pkg::key_t  round_key,
    output des_pkg::half_t f_out
);
    import des_pkg::*;

    key_t  mixed;
    half_t sub;

    assign mixed = expand(right_half) ^ round_key;

    // Box 1 takes the top six bits.
    always_comb begin
        for (int b = 0; b < 8; b++) begin
            sub[HALF_W-1-4*b -: 4] = sbox(3'(b), mixed[KEY_W-1-6*b -: 6]);
        end
    end

    assign f_out = permute(sub);

endmodule

[design/des_round_function_core.sv]
// DES Feistel round core: input register, f function, result register.
// A request goes from the input register to the result register, which sets m_tvalid.
// Throughput: one request per cycle unless m_tready stalls; the input register takes a
//   new request when empty or in the same cycle its contents move into the result reg.
// Result reg holds until m_tready; both stages full and m_tready low stall upstream.
// Reset: synchronous, active-low aresetn clears both valid flags; data regs not reset.
module des_round_function_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    // s_tdata, from bit 0 up: left_half[31:0], right_half[31:0], round_key[47:0]
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [des_pkg::S_TDATA_W-1:0]  s_tdata,
    // m_tdata, from bit 0 up: new_right[31:0], new_left[31:0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [des_pkg::M_TDATA_W-1:0]  m_tdata
);
    import des_pkg::*;

    // Input stage
    logic  in_valid_reg, in_valid_next;
    half_t left_reg, right_reg;
    key_t  key_reg;

    // Result stage
    logic  out_valid_reg, out_valid_next;
    half_t new_right_reg, new_left_reg;

    half_t f_val;
    logic  s_accept;
    logic  load_out;    // input stage moves into result stage this cycle

    assign load_out = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || load_out;
    assign s_accept = s_tvalid && s_tready;

    assign in_valid_next  = s_accept || (in_valid_reg && !load_out);
    assign out_valid_next = load_out || (out_valid_reg && !m_tready);

    des_feistel_f u_f (
        .right_half (right_reg),
        .round_key  (key_reg),
        .f_out      (f_val)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: capture a new request, or load a finished round.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            left_reg  <= s_tdata[HALF_W-1:0];
            right_reg <= s_tdata[2*HALF_W-1:HALF_W];
            key_reg   <= s_tdata[S_TDATA_W-1:2*HALF_W];
        end
        if (load_out) begin
            new_right_reg <= left_reg ^ f_val;
            new_left_reg  <= right_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {new_left_reg, new_right_reg};

    // A request moving out of the input stage lands in the result stage.
    a_load_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> out_valid_reg)
        else $error("result stage empty after load");

    // An accepted request is held in the input stage next cycle.
    a_accept_held: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> in_valid_reg)
        else $error("accepted request lost");

    // A stalled input stage keeps its payload.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !load_out) |=>
            (in_valid_reg && $stable(right_reg) && $stable(left_reg) && $stable(key_reg)))
        else $error("input stage changed while stalled");

    // New left half is the old right half of the request that was loaded.
    a_left_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> (m_tdata[M_TDATA_W-1:HALF_W] == $past(right_reg)))
        else $error("new_left mismatch");

endmodule
